// File: src/flha_pkg.sv
// shared constants, header type and status codes for the heap allocator
package flha_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int ALIGN_BYTES  = 8;
  localparam int HEADER_BYTES = 24;
  localparam int PAYLOAD_SKIP = 12;

  localparam int GRANULES = HEAP_BYTES / ALIGN_BYTES;
  localparam int HDR_G    = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int USABLE   = GRANULES * ALIGN_BYTES;
  localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
  localparam int AW       = $clog2(GRANULES);

  localparam int REQ_W    = 13;
  localparam int ADDR_W   = 12;
  localparam int BYTES_W  = 13;
  localparam int NEED_W   = REQ_W - ALIGN_SH + 1;
  localparam int WIDE_W   = 32;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_DFREE = 2'd3;

  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic          start;
    logic          is_free;
    logic [AW-1:0] size;
  } hdr_t;

  localparam int HDR_W = AW + 2;

endpackage

// File: src/flha_ram.sv
// generic single write port ram with registered read
module flha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

// File: src/free_list_heap_allocator.sv
// heap allocator top level: request sequencer around the block header ram
//
// The heap is kept as a chain of block headers in one ram, one entry per
// granule, read through a registered port. An allocate walks the chain
// block by block from the first block, then writes the chosen header and,
// if the block splits, a header for the remainder; first fit stops at the
// first block that fits. A free checks the address, reads its header and
// the one after it, walks block by block to its predecessor and writes
// back in three steps (FWR1 to FWR3). After reset, and after any range or
// double-free error, the ram is swept one entry a cycle over all GRANULES
// (512) entries to rebuild the single free block; no request is taken
// during the sweep, configuration writes are.
module free_list_heap_allocator
  import flha_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [REQ_W-1:0]   in_req_size,
  input  logic [ADDR_W-1:0]  in_block_addr,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [ADDR_W-1:0]  out_alloc_addr,
  output logic [BYTES_W-1:0] out_granted_bytes,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_AWALK = 12'b0000_0000_0100,
    S_AWR1  = 12'b0000_0000_1000,
    S_AWR2  = 12'b0000_0001_0000,
    S_FCHK  = 12'b0000_0010_0000,
    S_FNEXT = 12'b0000_0100_0000,
    S_FWALK = 12'b0000_1000_0000,
    S_FWR1  = 12'b0001_0000_0000,
    S_FWR2  = 12'b0010_0000_0000,
    S_FWR3  = 12'b0100_0000_0000,
    S_RESP  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW:0]        cur_r, cur_nxt;
  logic [NEED_W-1:0]  need_r, need_nxt;
  logic [AW-1:0]      pick_r, pick_nxt, pick_size_r, pick_size_nxt;
  logic [AW-1:0]      slack_r, slack_nxt;
  logic               found_r, found_nxt;
  logic [AW-1:0]      tgt_r, tgt_nxt, tsz_r, tsz_nxt, nx_r, nx_nxt;
  logic               clr_nx_r, clr_nx_nxt;
  logic [AW-1:0]      prev_r, prev_nxt, psz_r, psz_nxt;
  logic               prev_free_r, prev_free_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic               err_r, err_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic [BYTES_W-1:0] res_bytes_r, res_bytes_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [BYTES_W-1:0] out_bytes_r, out_bytes_nxt;
  logic [1:0]         policy_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  hdr_t              ram_wdata;
  logic [HDR_W-1:0]  ram_rdata;
  hdr_t              rd;

  flha_ram #(.WIDTH(HDR_W), .DEPTH(GRANULES)) u_hdr_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign rd = hdr_t'(ram_rdata);

  // walk helpers
  logic [WIDE_W-1:0] end_w, req_w, hb_w, g2_w, bytes_w, addr_w;
  logic [NEED_W-1:0] need_calc;
  logic              fit, take, first_pol, split, resp_go, free_bad;
  logic [AW-1:0]     slack, gsz;

  always_comb begin
    end_w     = WIDE_W'(cur_r) + WIDE_W'(HDR_G) + WIDE_W'(rd.size);
    req_w     = WIDE_W'(in_req_size);
    need_calc = NEED_W'(req_w >> ALIGN_SH);
    if (in_req_size[ALIGN_SH-1:0] != '0 || in_req_size == '0) begin
      need_calc = need_calc + NEED_W'(1);
    end
    hb_w      = WIDE_W'(in_block_addr) - WIDE_W'(PAYLOAD_SKIP);
    free_bad  = (WIDE_W'(in_block_addr) < WIDE_W'(PAYLOAD_SKIP)) ||
                (hb_w[ALIGN_SH-1:0] != '0) || (hb_w >= WIDE_W'(USABLE));
    fit       = rd.is_free && (WIDE_W'(rd.size) >= WIDE_W'(need_r));
    slack     = rd.size - AW'(need_r);
    first_pol = (policy_r != POL_BEST) && (policy_r != POL_WORST);
    priority if (policy_r == POL_BEST) begin
      take = fit && (!found_r || slack <= slack_r);
    end else if (policy_r == POL_WORST) begin
      take = fit && (!found_r || slack >= slack_r);
    end else begin
      take = fit && !found_r;
    end
    split   = (pick_size_r - AW'(need_r)) >= AW'(HDR_G);
    gsz     = split ? AW'(need_r) : pick_size_r;
    g2_w    = WIDE_W'(pick_r) + WIDE_W'(HDR_G) + WIDE_W'(need_r);
    bytes_w = WIDE_W'(gsz) << ALIGN_SH;
    addr_w  = (WIDE_W'(pick_r) << ALIGN_SH) + WIDE_W'(PAYLOAD_SKIP);
    resp_go = !out_valid_r || out_ready;
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    need_nxt       = need_r;
    pick_nxt       = pick_r;
    pick_size_nxt  = pick_size_r;
    slack_nxt      = slack_r;
    found_nxt      = found_r;
    tgt_nxt        = tgt_r;
    tsz_nxt        = tsz_r;
    nx_nxt         = nx_r;
    clr_nx_nxt     = clr_nx_r;
    prev_nxt       = prev_r;
    psz_nxt        = psz_r;
    prev_free_nxt  = prev_free_r;
    clr_nxt        = clr_r;
    err_nxt        = err_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_bytes_nxt  = res_bytes_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_bytes_nxt  = out_bytes_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (clr_r == '0) begin
          ram_wdata = '{start: 1'b1, is_free: 1'b1, size: AW'(GRANULES - HDR_G)};
        end
        if (clr_r == AW'(GRANULES - 1)) begin
          state_nxt = S_IDLE;
          err_nxt   = 1'b0;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          found_nxt      = 1'b0;
          clr_nx_nxt     = 1'b0;
          prev_free_nxt  = 1'b0;
          err_nxt        = 1'b0;
          res_status_nxt = ST_OK;
          res_addr_nxt   = '0;
          res_bytes_nxt  = '0;
          need_nxt       = need_calc;
          cur_nxt        = '0;
          if (!in_req_type) begin
            ram_raddr = '0;
            state_nxt = S_AWALK;
          end else if (free_bad) begin
            res_status_nxt = ST_RANGE;
            err_nxt        = 1'b1;
            state_nxt      = S_RESP;
          end else begin
            tgt_nxt   = AW'(hb_w >> ALIGN_SH);
            ram_raddr = AW'(hb_w >> ALIGN_SH);
            state_nxt = S_FCHK;
          end
        end
      end
      S_AWALK: begin
        if (take) begin
          found_nxt     = 1'b1;
          pick_nxt      = cur_r[AW-1:0];
          slack_nxt     = slack;
          pick_size_nxt = rd.size;
        end
        if ((first_pol && fit) || end_w >= WIDE_W'(GRANULES)) begin
          if (found_r || take) begin
            state_nxt = S_AWR1;
          end else begin
            res_status_nxt = ST_NOFIT;
            state_nxt      = S_RESP;
          end
        end else begin
          ram_raddr = AW'(end_w);
          cur_nxt   = (AW + 1)'(end_w);
        end
      end
      S_AWR1: begin
        ram_we        = 1'b1;
        ram_waddr     = pick_r;
        ram_wdata     = '{start: 1'b1, is_free: 1'b0, size: gsz};
        res_addr_nxt  = ADDR_W'(addr_w);
        res_bytes_nxt = BYTES_W'(bytes_w);
        state_nxt     = split ? S_AWR2 : S_RESP;
      end
      S_AWR2: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(g2_w);
        ram_wdata = '{start: 1'b1, is_free: 1'b1,
                      size: pick_size_r - AW'(need_r) - AW'(HDR_G)};
        state_nxt = S_RESP;
      end
      S_FCHK: begin
        if (!rd.start) begin
          res_status_nxt = ST_RANGE;
          err_nxt        = 1'b1;
          state_nxt      = S_RESP;
        end else if (rd.is_free) begin
          res_status_nxt = ST_DFREE;
          err_nxt        = 1'b1;
          state_nxt      = S_RESP;
        end else begin
          tsz_nxt = rd.size;
          if (WIDE_W'(tgt_r) + WIDE_W'(HDR_G) + WIDE_W'(rd.size) < WIDE_W'(GRANULES)) begin
            nx_nxt    = tgt_r + AW'(HDR_G) + rd.size;
            ram_raddr = tgt_r + AW'(HDR_G) + rd.size;
            state_nxt = S_FNEXT;
          end else if (tgt_r == '0) begin
            state_nxt = S_FWR1;
          end else begin
            state_nxt = S_FWALK;
          end
        end
      end
      S_FNEXT: begin
        if (rd.start && rd.is_free) begin
          tsz_nxt    = tsz_r + AW'(HDR_G) + rd.size;
          clr_nx_nxt = 1'b1;
        end
        state_nxt = (tgt_r == '0) ? S_FWR1 : S_FWALK;
      end
      S_FWALK: begin
        if (end_w >= WIDE_W'(tgt_r)) begin
          prev_free_nxt = (end_w == WIDE_W'(tgt_r)) && rd.is_free;
          prev_nxt      = cur_r[AW-1:0];
          psz_nxt       = rd.size;
          state_nxt     = S_FWR1;
        end else begin
          ram_raddr = AW'(end_w);
          cur_nxt   = (AW + 1)'(end_w);
        end
      end
      S_FWR1: begin
        ram_we    = clr_nx_r;
        ram_waddr = nx_r;
        state_nxt = S_FWR2;
      end
      S_FWR2: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r;
        if (!prev_free_r) begin
          ram_wdata = '{start: 1'b1, is_free: 1'b1, size: tsz_r};
        end
        state_nxt = S_FWR3;
      end
      S_FWR3: begin
        ram_we    = prev_free_r;
        ram_waddr = prev_r;
        ram_wdata = '{start: 1'b1, is_free: 1'b1, size: psz_r + AW'(HDR_G) + tsz_r};
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (resp_go) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_bytes_nxt  = res_bytes_r;
          clr_nxt        = '0;
          state_nxt      = err_r ? S_CLEAR : S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      policy_r    <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    need_r       <= need_nxt;
    pick_r       <= pick_nxt;
    pick_size_r  <= pick_size_nxt;
    slack_r      <= slack_nxt;
    found_r      <= found_nxt;
    tgt_r        <= tgt_nxt;
    tsz_r        <= tsz_nxt;
    nx_r         <= nx_nxt;
    clr_nx_r     <= clr_nx_nxt;
    prev_r       <= prev_nxt;
    psz_r        <= psz_nxt;
    prev_free_r  <= prev_free_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_bytes_r  <= res_bytes_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_bytes_r  <= out_bytes_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_alloc_addr    = out_addr_r;
  assign out_granted_bytes = out_bytes_r;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("header ram written while idle");

  a_err_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && resp_go && err_r) |=> (state_r == S_CLEAR && clr_r == '0))
    else $error("error result not followed by heap sweep");

  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && err_r) |-> (res_status_r == ST_RANGE || res_status_r == ST_DFREE))
    else $error("error flag without error status");

  a_ok_alloc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AWR1) |=> (res_bytes_r != '0))
    else $error("granted block of zero bytes");

endmodule

// File: bench/free_list_heap_allocator_tb.sv
// self-checking testbench for the free-list heap allocator
`timescale 1ns / 1ps

module free_list_heap_allocator_tb;
  import flha_pkg::*;

  localparam logic       REQ_ALLOC  = 1'b0;
  localparam logic       REQ_FREE   = 1'b1;
  localparam logic [1:0] POL_FIRST  = 2'd0;
  localparam logic [1:0] POL_UNUSED = 2'd3;
  localparam int         HDR_SPAN   = HDR_G * ALIGN_BYTES;
  localparam int         SETTLE     = 700;
  localparam int         CYCLE_CAP  = 3000000;

  typedef struct packed {
    logic              kind;
    logic [REQ_W-1:0]  size;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
  } grant_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_req_type;
  logic [REQ_W-1:0] in_req_size;
  logic [ADDR_W-1:0] in_block_addr;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic [ADDR_W-1:0] out_alloc_addr;
  logic [BYTES_W-1:0] out_granted_bytes;
  logic cfg_we;
  logic [1:0] cfg_wdata;

  free_list_heap_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_req_size(in_req_size), .in_block_addr(in_block_addr),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_alloc_addr(out_alloc_addr), .out_granted_bytes(out_granted_bytes),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  req_t   pending_reqs[$];
  grant_t expected_grants[$];
  int     fails, grants_seen, allocs_ok, frees_ok, heap_errors, nofits;
  int     cycles;
  bit     quiet;

  // heap mirror
  bit         blk_start[GRANULES];
  bit         blk_free[GRANULES];
  int         blk_size[GRANULES];
  logic [1:0] policy;

  function automatic int span(int g);
    return (HDR_SPAN + blk_size[g]) / ALIGN_BYTES;
  endfunction

  function automatic void heap_clear();
    for (int g = 0; g < GRANULES; g++) begin
      blk_start[g] = 0;
      blk_free[g] = 0;
      blk_size[g] = 0;
    end
    blk_start[0] = 1;
    blk_free[0] = 1;
    blk_size[0] = USABLE - HDR_SPAN;
  endfunction

  function automatic grant_t heap_step(req_t r);
    grant_t res;
    int need, g, pick, slack, best_slack, nx, p, hb;
    bit found, take;
    res = '0;
    if (r.kind == REQ_ALLOC) begin
      need = r.size;
      if (need % ALIGN_BYTES != 0 || need == 0) need += ALIGN_BYTES - need % ALIGN_BYTES;
      found = 0;
      pick = 0;
      best_slack = 0;
      g = 0;
      while (g < GRANULES) begin
        if (blk_free[g] && blk_size[g] >= need) begin
          slack = blk_size[g] - need;
          if (policy == POL_BEST) take = !found || slack <= best_slack;
          else if (policy == POL_WORST) take = !found || slack >= best_slack;
          else take = !found;
          if (take) begin
            found = 1;
            pick = g;
            best_slack = slack;
          end
          if (policy != POL_BEST && policy != POL_WORST) break;
        end
        g += span(g);
      end
      if (!found) begin
        res.status = ST_NOFIT;
        nofits++;
        return res;
      end
      if (blk_size[pick] - need >= HDR_SPAN) begin
        nx = pick + (HDR_SPAN + need) / ALIGN_BYTES;
        blk_start[nx] = 1;
        blk_free[nx] = 1;
        blk_size[nx] = blk_size[pick] - need - HDR_SPAN;
        blk_size[pick] = need;
      end
      blk_free[pick] = 0;
      res.status = ST_OK;
      res.addr = ADDR_W'(pick * ALIGN_BYTES + PAYLOAD_SKIP);
      res.bytes = BYTES_W'(blk_size[pick]);
      allocs_ok++;
      return res;
    end
    hb = int'(r.addr) - PAYLOAD_SKIP;
    if (r.addr < PAYLOAD_SKIP || hb % ALIGN_BYTES != 0 || hb >= USABLE
        || !blk_start[hb / ALIGN_BYTES]) begin
      res.status = ST_RANGE;
      heap_clear();
      heap_errors++;
      return res;
    end
    g = hb / ALIGN_BYTES;
    if (blk_free[g]) begin
      res.status = ST_DFREE;
      heap_clear();
      heap_errors++;
      return res;
    end
    blk_free[g] = 1;
    nx = g + span(g);
    if (nx < GRANULES && blk_start[nx] && blk_free[nx]) begin
      blk_size[g] += HDR_SPAN + blk_size[nx];
      blk_start[nx] = 0;
      blk_free[nx] = 0;
      blk_size[nx] = 0;
    end
    if (g > 0) begin
      p = 0;
      while (p + span(p) < g) p += span(p);
      if (p + span(p) == g && blk_free[p]) begin
        blk_size[p] += HDR_SPAN + blk_size[g];
        blk_start[g] = 0;
        blk_free[g] = 0;
        blk_size[g] = 0;
      end
    end
    res.status = ST_OK;
    frees_ok++;
    return res;
  endfunction

  task automatic post(logic kind, int size, int addr);
    req_t r;
    r.kind = kind;
    r.size = REQ_W'(size);
    r.addr = ADDR_W'(addr);
    pending_reqs.push_back(r);
    expected_grants.push_back(heap_step(r));
  endtask

  // pick a block start that is in use (or free, for double-free noise)
  function automatic int find_block(bit want_free);
    int cands[$];
    int g;
    g = 0;
    while (g < GRANULES) begin
      if (blk_free[g] == want_free) cands.push_back(g);
      g += span(g);
    end
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(0, cands.size() - 1)] * ALIGN_BYTES + PAYLOAD_SKIP;
  endfunction

  task automatic random_burst(int count);
    int a, pick, sz;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      a = find_block(0);
      if (pick < 3) begin
        a = find_block(1);
        post(REQ_FREE, $urandom_range(0, 8191), a < 0 ? $urandom_range(0, 4095) : a);
      end else if (pick < 5) begin
        post(REQ_FREE, $urandom_range(0, 8191), $urandom_range(0, 4095));
      end else if (pick < 50 && a >= 0) begin
        post(REQ_FREE, $urandom_range(0, 8191), a);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) sz = $urandom_range(0, 64);
        else if (pick < 95) sz = $urandom_range(0, 600);
        else sz = $urandom_range(0, 4096);
        post(REQ_ALLOC, sz, $urandom_range(0, 4095));
      end
    end
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_grants.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_policy(logic [1:0] p);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    policy = p;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stimulus and phases
  initial begin
    logic [1:0] phases[6];
    int a;
    phases = '{POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED, POL_BEST, POL_FIRST};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quiet = 0;
    policy = POL_FIRST;
    heap_clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, splits, whole grants and each error kind
    post(REQ_ALLOC, 0, 4095);
    post(REQ_ALLOC, 4096, 0);
    post(REQ_ALLOC, 1, 0);
    post(REQ_ALLOC, 13, 0);
    post(REQ_ALLOC, 4, 0);
    post(REQ_FREE, 0, 12 + 8 * 4);
    post(REQ_FREE, 0, 12 + 8 * 4);
    post(REQ_ALLOC, USABLE - HDR_SPAN, 0);
    post(REQ_FREE, 8191, 12);
    post(REQ_ALLOC, USABLE - 2 * HDR_SPAN - 8, 0);
    post(REQ_ALLOC, 16, 0);
    post(REQ_FREE, 0, 12);
    post(REQ_FREE, 0, 0);
    post(REQ_FREE, 0, 13);
    post(REQ_FREE, 0, 4095);
    post(REQ_ALLOC, 32, 0);
    post(REQ_FREE, 0, 20);
    post(REQ_ALLOC, 40, 0);
    post(REQ_ALLOC, 40, 0);
    post(REQ_ALLOC, 40, 0);
    post(REQ_FREE, 0, 12);
    post(REQ_FREE, 0, 12 + 2 * (HDR_SPAN + 40));
    post(REQ_FREE, 0, 12 + HDR_SPAN + 40);
    post(REQ_FREE, 0, 12 + HDR_SPAN + 40);
    drain();

    foreach (phases[i]) begin
      write_policy(phases[i]);
      if (i == 5) quiet = 1;
      random_burst(190);
      // fragment then probe with mid sizes so fit policies diverge
      for (int k = 0; k < 6; k++) post(REQ_ALLOC, $urandom_range(8, 120), 0);
      a = find_block(0);
      if (a >= 0) post(REQ_FREE, 0, a);
      post(REQ_ALLOC, $urandom_range(1, 80), 0);
      drain();
    end

    $display("covered %0d results: %0d allocations, %0d frees, %0d no-fit, %0d heap errors",
             grants_seen, allocs_ok, frees_ok, nofits, heap_errors);
    $display("fit policies first, best, worst and the unused code were all exercised");
    if (fails == 0) begin
      $display("[free_list_heap_allocator] OK");
    end else begin
      $display("[free_list_heap_allocator] ERROR");
    end
    $finish;
  end

  // request driver
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req_type <= REQ_ALLOC;
      in_req_size <= '0;
      in_block_addr <= '0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_req_type <= pending_reqs[0].kind;
        in_req_size <= pending_reqs[0].size;
        in_block_addr <= pending_reqs[0].addr;
        void'(pending_reqs.pop_front());
        if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor with random backpressure
  int recv_gap;
  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        grants_seen++;
        if (expected_grants.size() == 0) begin
          $error("unexpected beat: status %0d addr %0d bytes %0d",
                 out_status, out_alloc_addr, out_granted_bytes);
          fails++;
        end else begin
          want = expected_grants.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fails++;
          end
          if (out_alloc_addr !== want.addr) begin
            $error("alloc_addr: expected %0d, got %0d", want.addr, out_alloc_addr);
            fails++;
          end
          if (out_granted_bytes !== want.bytes) begin
            $error("granted_bytes: expected %0d, got %0d", want.bytes, out_granted_bytes);
            fails++;
          end
        end
      end
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        recv_gap <= $urandom_range(0, 13);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[free_list_heap_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    fails = 0;
    grants_seen = 0;
    allocs_ok = 0;
    frees_ok = 0;
    heap_errors = 0;
    nofits = 0;
  end

endmodule

// File: filelist.f
src/flha_pkg.sv
src/flha_ram.sv
src/free_list_heap_allocator.sv
bench/free_list_heap_allocator_tb.sv
